### rtl/lhsg_pkg.sv
// lhsg_pkg: shared types and constants for the LFSR hop sequence generator.
// No dependencies.
package lhsg_pkg;

	localparam int unsigned LFSR_W      = 7;
	localparam int unsigned OFFSET_W    = 8;
	localparam int unsigned HOP_INDEX_W = 5;

	localparam logic [LFSR_W-1:0] LFSR_TAPS   = 7'h60;
	localparam logic [LFSR_W-1:0] CHANNEL_MOD = 7'd127;
	localparam logic [LFSR_W-1:0] STEP_BOUND  = 7'd127;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_CHECK,
		ST_SCAN,
		ST_DECIDE,
		ST_EMIT
	} state_t;

endpackage

### rtl/lhsg_step.sv
// lhsg_step: one Galois LFSR step (taps 0x60) and the candidate channel
// (next lfsr + offset) mod 127. Depends on lhsg_pkg.
module lhsg_step (
	input  logic [lhsg_pkg::LFSR_W-1:0]   lfsr,
	input  logic [lhsg_pkg::OFFSET_W-1:0] offset,
	output logic [lhsg_pkg::LFSR_W-1:0]   lfsr_next,
	output logic [lhsg_pkg::LFSR_W-1:0]   candidate
);

	logic [8:0] sum;
	logic [7:0] fold;

	always_comb begin
		lfsr_next = {1'b0, lfsr[lhsg_pkg::LFSR_W-1:1]};
		if (lfsr[0]) begin
			lfsr_next = lfsr_next ^ lhsg_pkg::LFSR_TAPS;
		end
	end

	// 128 == 1 (mod 127): fold the top bits onto the low seven, then one correction
	assign sum  = {2'b00, lfsr_next} + {1'b0, offset};
	assign fold = {6'b0, sum[8:7]} + {1'b0, sum[6:0]};

	always_comb begin
		if (fold >= {1'b0, lhsg_pkg::CHANNEL_MOD}) begin
			candidate = 7'(fold - {1'b0, lhsg_pkg::CHANNEL_MOD});
		end else begin
			candidate = fold[6:0];
		end
	end

endmodule

### rtl/lhsg_mem.sv
// lhsg_mem: single-write, single-read store of chosen channels, registered read.
// Depends on lhsg_pkg.
module lhsg_mem #(
	parameter int unsigned DEPTH = 20,
	parameter int unsigned AW    = 5
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [lhsg_pkg::LFSR_W-1:0]   wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [lhsg_pkg::LFSR_W-1:0]   rdata
);

	logic [lhsg_pkg::LFSR_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/lfsr_hop_sequence_generator.sv
// lfsr_hop_sequence_generator: top level, sequencer and duplicate-scan compare.
// Depends on lhsg_pkg, lhsg_step, lhsg_mem.
//
// A request (start while busy is low) loads the seed and offset. The block then
// walks the 7-bit LFSR, one step and one candidate per pass; an in-range
// candidate is compared against the channels already chosen, one stored entry
// per cycle through the store's registered read port. Once HOP_COUNT channels
// are found, or 127 steps have run, the chosen channels are sent out one per
// cycle on consecutive cycles, each marked by strobe, with last on the final
// one. The receiver cannot stall: results must be taken as they appear. Each
// LFSR step runs through the STEP, CHECK and DECIDE states, and an in-range
// candidate adds a SCAN visit per stored entry, up to n when n channels are
// already held (the scan stops at the first match), so the serial duplicate
// scan sets the length of a request; busy stays high throughout. A zero seed
// gives one channel or none after the full 127 steps.
module lfsr_hop_sequence_generator #(
	parameter int unsigned HOP_COUNT   = 20,
	parameter int unsigned MAX_CHANNEL = 69
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [lhsg_pkg::OFFSET_W-1:0]      offset,
	input  logic [lhsg_pkg::LFSR_W-1:0]        seed,
	output logic                               strobe,
	output logic [lhsg_pkg::HOP_INDEX_W-1:0]   hop_index,
	output logic [lhsg_pkg::LFSR_W-1:0]        channel,
	output logic                               last
);

	localparam int unsigned AW = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;
	localparam int unsigned CW = $clog2(HOP_COUNT + 1);

	lhsg_pkg::state_t state_q, state_d;

	logic [lhsg_pkg::LFSR_W-1:0]   lfsr_q;
	logic [lhsg_pkg::OFFSET_W-1:0] offset_q;
	logic [lhsg_pkg::LFSR_W-1:0]   cand_q;
	logic [lhsg_pkg::LFSR_W-1:0]   steps_q;
	logic [CW-1:0]                 count_q;
	logic [AW-1:0]                 scan_q;
	logic [AW-1:0]                 emit_q;

	logic [lhsg_pkg::LFSR_W-1:0]   lfsr_next;
	logic [lhsg_pkg::LFSR_W-1:0]   candidate;
	logic [lhsg_pkg::LFSR_W-1:0]   rd_data;

	logic          in_range;
	logic          match;
	logic          scan_end;
	logic          emit_end;
	logic          search_done;
	logic [CW-1:0] scan_nxt;
	logic [CW-1:0] emit_nxt;
	logic [CW-1:0] rd_idx;
	logic [AW-1:0] rd_addr;
	logic          we;

	lhsg_step u_step (
		.lfsr      (lfsr_q),
		.offset    (offset_q),
		.lfsr_next (lfsr_next),
		.candidate (candidate)
	);

	lhsg_mem #(
		.DEPTH (HOP_COUNT),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wdata (cand_q),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign in_range    = cand_q <= 7'(MAX_CHANNEL);
	assign match       = rd_data == cand_q;
	assign scan_nxt    = CW'(scan_q) + CW'(1);
	assign emit_nxt    = CW'(emit_q) + CW'(1);
	assign scan_end    = scan_nxt == count_q;
	assign emit_end    = emit_nxt == count_q;
	assign search_done = (count_q == CW'(HOP_COUNT)) || (steps_q == lhsg_pkg::STEP_BOUND);
	assign rd_addr     = (rd_idx < CW'(HOP_COUNT)) ? rd_idx[AW-1:0] : '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lhsg_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lhsg_pkg::ST_STEP;
				end
			end
			lhsg_pkg::ST_STEP: begin
				state_d = lhsg_pkg::ST_CHECK;
			end
			lhsg_pkg::ST_CHECK: begin
				if (!in_range || count_q == '0) begin
					state_d = lhsg_pkg::ST_DECIDE;
				end else begin
					state_d = lhsg_pkg::ST_SCAN;
				end
			end
			lhsg_pkg::ST_SCAN: begin
				if (match || scan_end) begin
					state_d = lhsg_pkg::ST_DECIDE;
				end
			end
			lhsg_pkg::ST_DECIDE: begin
				if (!search_done) begin
					state_d = lhsg_pkg::ST_STEP;
				end else if (count_q == '0) begin
					state_d = lhsg_pkg::ST_IDLE;
				end else begin
					state_d = lhsg_pkg::ST_EMIT;
				end
			end
			lhsg_pkg::ST_EMIT: begin
				if (emit_end) begin
					state_d = lhsg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lhsg_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and store control
	always_comb begin
		busy   = 1'b1;
		strobe = 1'b0;
		we     = 1'b0;
		rd_idx = '0;
		unique case (state_q)
			lhsg_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			lhsg_pkg::ST_STEP: begin
			end
			lhsg_pkg::ST_CHECK: begin
				we = in_range && (count_q == '0);
			end
			lhsg_pkg::ST_SCAN: begin
				we     = !match && scan_end;
				rd_idx = scan_nxt;
			end
			lhsg_pkg::ST_DECIDE: begin
			end
			lhsg_pkg::ST_EMIT: begin
				strobe = 1'b1;
				rd_idx = emit_nxt;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	assign hop_index = lhsg_pkg::HOP_INDEX_W'(emit_q);
	assign channel   = rd_data;
	assign last      = emit_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lhsg_pkg::ST_IDLE;
			lfsr_q  <= '0;
			count_q <= '0;
			steps_q <= '0;
			scan_q  <= '0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lhsg_pkg::ST_IDLE: begin
					if (start) begin
						lfsr_q  <= seed;
						count_q <= '0;
						steps_q <= '0;
					end
				end
				lhsg_pkg::ST_STEP: begin
					lfsr_q  <= lfsr_next;
					steps_q <= steps_q + 7'd1;
				end
				lhsg_pkg::ST_CHECK: begin
					scan_q <= '0;
				end
				lhsg_pkg::ST_SCAN: begin
					scan_q <= scan_nxt[AW-1:0];
				end
				lhsg_pkg::ST_DECIDE: begin
					emit_q <= '0;
				end
				lhsg_pkg::ST_EMIT: begin
					emit_q <= emit_nxt[AW-1:0];
				end
				default: begin
				end
			endcase
			if (we) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// request payload and candidate
	always_ff @(posedge clk) begin
		if (state_q == lhsg_pkg::ST_IDLE && start) begin
			offset_q <= offset;
		end
		if (state_q == lhsg_pkg::ST_STEP) begin
			cand_q <= candidate;
		end
	end

endmodule

### rtl/lhsg_checker.sv
// lhsg_checker: port-level checks for lfsr_hop_sequence_generator, with bind.
// Depends on lhsg_pkg.
module lhsg_checker #(
	parameter int unsigned MAX_CHANNEL = 69
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             strobe,
	input logic [lhsg_pkg::HOP_INDEX_W-1:0] hop_index,
	input logic [lhsg_pkg::LFSR_W-1:0]      channel,
	input logic                             last
);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy && channel <= 7'(MAX_CHANNEL))
		else $error("result outside a request or channel out of range");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && hop_index == $past(hop_index) + 5'd1)
		else $error("result burst broken or hop index out of order");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !busy && !strobe)
		else $error("block still busy after last result");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !strobe)
		else $error("request not taken");

endmodule

bind lfsr_hop_sequence_generator lhsg_checker #(
	.MAX_CHANNEL (MAX_CHANNEL)
) u_lhsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.hop_index (hop_index),
	.channel   (channel),
	.last      (last)
);
